@@ sv/sfp_pkg.sv @@
// Package for the start-of-frame parser: constants, register indexes,
// frame descriptor type and the CRC-8/ATM byte update.
// No dependencies.
package sfp_pkg;

  localparam int MAX_PAYLOAD_DFLT = 32;
  localparam int HEADER_LEN       = 5;
  localparam int QUEUE_DEPTH      = 2;

  localparam logic [7:0] START_ONE_RST = 8'hAA;
  localparam logic [7:0] START_TWO_RST = 8'h55;

  localparam logic REG_START_ONE = 1'b0;
  localparam logic REG_START_TWO = 1'b1;

  typedef struct packed {
    logic [7:0] src;
    logic [7:0] tgt;
    logic [7:0] cmd;
    logic [7:0] seq;
    logic [7:0] len;
    logic       bank;
  } desc_t;

  function automatic logic [7:0] crc8_atm(input logic [7:0] crc, input logic [7:0] b);
    logic [7:0] v;
    v = crc ^ b;
    for (int i = 0; i < 8; i++) begin
      v = v[7] ? ({v[6:0], 1'b0} ^ 8'h07) : {v[6:0], 1'b0};
    end
    return v;
  endfunction

endpackage

@@ sv/sfp_if.sv @@
// Valid/ready channel interfaces for received bytes and frame results.
// No dependencies.
interface sfp_rx_if;
  logic       valid;
  logic       ready;
  logic [7:0] rx_byte;
  modport source (output valid, output rx_byte, input ready);
  modport sink (input valid, input rx_byte, output ready);
endinterface

interface sfp_res_if;
  logic       valid;
  logic       ready;
  logic [7:0] src_addr;
  logic [7:0] target_addr;
  logic [7:0] command;
  logic [7:0] sequence_res;
  logic [5:0] payload_len;
  logic       has_payload;
  logic [4:0] byte_position;
  logic [7:0] payload_byte;
  logic       last;
  modport source (output valid, output src_addr, output target_addr, output command,
                  output sequence_res, output payload_len, output has_payload,
                  output byte_position, output payload_byte, output last, input ready);
  modport sink (input valid, input src_addr, input target_addr, input command,
                input sequence_res, input payload_len, input has_payload,
                input byte_position, input payload_byte, input last, output ready);
endinterface

@@ sv/sfp_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module sfp_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

@@ sv/sfp_front.sv @@
// Front end: start-byte hunt, header capture, payload write, running CRC.
// Depends on sfp_pkg and sfp_rx_if; writes the payload RAM, pushes descriptors.
module sfp_front #(
  parameter int MAX_PAYLOAD = sfp_pkg::MAX_PAYLOAD_DFLT,
  parameter int IDX_W = (MAX_PAYLOAD > 1) ? $clog2(MAX_PAYLOAD) : 1
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 cfg_we,
  input  logic                 cfg_index,
  input  logic [7:0]           cfg_data,
  sfp_rx_if.sink               rx,
  output logic                 ram_we,
  output logic [IDX_W:0]       ram_waddr,
  output logic [7:0]           ram_wdata,
  input  logic                 q_full,
  output logic                 q_push,
  output sfp_pkg::desc_t       q_desc
);

  localparam int CNT_W = $clog2(MAX_PAYLOAD + 1);
  localparam logic [7:0] MAX8 = 8'(MAX_PAYLOAD);
  localparam logic [CNT_W-1:0] MAXC = CNT_W'(MAX_PAYLOAD);

  localparam logic [2:0] PH_SOF1    = 3'd0;
  localparam logic [2:0] PH_SOF2    = 3'd1;
  localparam logic [2:0] PH_HEADER  = 3'd2;
  localparam logic [2:0] PH_PAYLOAD = 3'd3;
  localparam logic [2:0] PH_CRC     = 3'd4;

  logic [7:0]       sb1;
  logic [7:0]       sb2;
  logic [2:0]       phase;
  logic [2:0]       hcnt;
  logic [CNT_W-1:0] pcnt;
  logic [7:0]       crc;
  logic [7:0]       crc_next;
  logic             wr_bank;
  logic [7:0]       h_src;
  logic [7:0]       h_tgt;
  logic [7:0]       h_cmd;
  logic [7:0]       h_seq;
  logic [7:0]       h_len;
  logic             accept;
  logic [7:0]       b;

  assign rx.ready = !q_full;
  assign accept   = rx.valid && rx.ready;
  assign b        = rx.rx_byte;
  assign crc_next = sfp_pkg::crc8_atm(crc, b);

  assign ram_we    = accept && (phase == PH_PAYLOAD) && (pcnt < MAXC);
  assign ram_waddr = {wr_bank, pcnt[IDX_W-1:0]};
  assign ram_wdata = b;

  assign q_push = accept && (phase == PH_CRC) && (b == crc);
  assign q_desc = '{src: h_src, tgt: h_tgt, cmd: h_cmd, seq: h_seq, len: h_len,
                    bank: wr_bank};

  always_ff @(posedge clk) begin
    if (rst) begin
      sb1     <= sfp_pkg::START_ONE_RST;
      sb2     <= sfp_pkg::START_TWO_RST;
      phase   <= PH_SOF1;
      hcnt    <= '0;
      pcnt    <= '0;
      crc     <= '0;
      wr_bank <= 1'b0;
    end else begin
      if (cfg_we) begin
        unique case (cfg_index)
          sfp_pkg::REG_START_ONE: sb1 <= cfg_data;
          sfp_pkg::REG_START_TWO: sb2 <= cfg_data;
        endcase
      end
      if (accept) begin
        unique case (phase)
          PH_SOF1: begin
            if (b == sb1) phase <= PH_SOF2;
          end
          PH_SOF2: begin
            if (b == sb2) begin
              phase <= PH_HEADER;
              hcnt  <= '0;
              crc   <= '0;
            end else if (b != sb1) begin
              phase <= PH_SOF1;
              hcnt  <= '0;
              pcnt  <= '0;
            end
          end
          PH_HEADER: begin
            unique case (hcnt)
              3'd0: begin
                h_src <= b;
                hcnt  <= hcnt + 3'd1;
                crc   <= crc_next;
              end
              3'd1: begin
                h_tgt <= b;
                hcnt  <= hcnt + 3'd1;
                crc   <= crc_next;
              end
              3'd2: begin
                h_cmd <= b;
                hcnt  <= hcnt + 3'd1;
                crc   <= crc_next;
              end
              3'd3: begin
                h_seq <= b;
                hcnt  <= hcnt + 3'd1;
                crc   <= crc_next;
              end
              3'd4: begin
                h_len <= b;
                crc   <= crc_next;
                if (b > MAX8) begin
                  phase <= PH_SOF1;
                  hcnt  <= '0;
                  pcnt  <= '0;
                end else if (b == 8'd0) begin
                  hcnt  <= hcnt + 3'd1;
                  phase <= PH_CRC;
                end else begin
                  hcnt  <= hcnt + 3'd1;
                  pcnt  <= '0;
                  phase <= PH_PAYLOAD;
                end
              end
              default: begin
                phase <= PH_SOF1;
                hcnt  <= '0;
                pcnt  <= '0;
              end
            endcase
          end
          PH_PAYLOAD: begin
            if (pcnt >= MAXC) begin
              phase <= PH_SOF1;
              hcnt  <= '0;
              pcnt  <= '0;
            end else begin
              pcnt <= pcnt + CNT_W'(1);
              crc  <= crc_next;
              if (8'(pcnt) + 8'd1 == h_len) phase <= PH_CRC;
            end
          end
          PH_CRC: begin
            if (b == crc) wr_bank <= !wr_bank;
            phase <= PH_SOF1;
            hcnt  <= '0;
            pcnt  <= '0;
          end
          default: begin
            phase <= PH_SOF1;
            hcnt  <= '0;
            pcnt  <= '0;
          end
        endcase
      end
    end
  end

  a_payload_len_ok: assert property (@(posedge clk) disable iff (rst)
    (phase == PH_PAYLOAD) |-> (h_len != 8'd0) && (h_len <= MAX8))
    else $error("payload phase with bad length");

  a_push_flips_bank: assert property (@(posedge clk) disable iff (rst)
    q_push |=> (wr_bank != $past(wr_bank)) && (phase == PH_SOF1))
    else $error("push without bank swap");

endmodule

@@ sv/sfp_queue.sv @@
// Short descriptor queue between front and back ends.
// Depends on sfp_pkg for the descriptor type and depth.
module sfp_queue (
  input  logic           clk,
  input  logic           rst,
  input  logic           push,
  input  sfp_pkg::desc_t push_desc,
  output logic           full,
  input  logic           pop,
  output logic           head_valid,
  output sfp_pkg::desc_t head_desc
);

  localparam int PTR_W = $clog2(sfp_pkg::QUEUE_DEPTH);
  localparam int CNT_W = $clog2(sfp_pkg::QUEUE_DEPTH + 1);

  sfp_pkg::desc_t   slots [sfp_pkg::QUEUE_DEPTH];
  logic [PTR_W-1:0] wptr;
  logic [PTR_W-1:0] rptr;
  logic [CNT_W-1:0] count;

  assign full       = (count == CNT_W'(sfp_pkg::QUEUE_DEPTH));
  assign head_valid = (count != '0);
  assign head_desc  = slots[rptr];

  always_ff @(posedge clk) begin
    if (push) slots[wptr] <= push_desc;
    if (rst) begin
      wptr  <= '0;
      rptr  <= '0;
      count <= '0;
    end else begin
      if (push) wptr <= wptr + PTR_W'(1);
      if (pop) rptr <= rptr + PTR_W'(1);
      count <= count + CNT_W'(push) - CNT_W'(pop);
    end
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (rst) push |-> !full)
    else $error("push into full queue");

  a_no_underflow: assert property (@(posedge clk) disable iff (rst) pop |-> head_valid)
    else $error("pop from empty queue");

endmodule

@@ sv/sfp_back.sv @@
// Back end: walks the head frame's RAM payload; one result per byte, one if none.
// Depends on sfp_pkg and sfp_res_if; reads the payload RAM, pops descriptors.
module sfp_back #(
  parameter int MAX_PAYLOAD = sfp_pkg::MAX_PAYLOAD_DFLT,
  parameter int IDX_W = (MAX_PAYLOAD > 1) ? $clog2(MAX_PAYLOAD) : 1
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           q_valid,
  input  sfp_pkg::desc_t q_desc,
  output logic           q_pop,
  output logic [IDX_W:0] ram_raddr,
  input  logic [7:0]     ram_rdata,
  sfp_res_if.source      res
);

  logic [IDX_W-1:0] k;
  logic [IDX_W-1:0] k_pend;
  logic             last_pend;
  logic             rd_pend;
  logic             issue;
  logic             is_last;
  logic             has_pl;

  assign issue     = q_valid && !rd_pend && (!res.valid || res.ready);
  assign is_last   = (q_desc.len == 8'd0) || (8'(k) + 8'd1 == q_desc.len);
  assign has_pl    = (q_desc.len != 8'd0);
  assign ram_raddr = {q_desc.bank, k};
  assign q_pop     = rd_pend && last_pend;

  always_ff @(posedge clk) begin
    if (issue) begin
      k_pend    <= k;
      last_pend <= is_last;
    end
    if (rd_pend) begin
      res.src_addr      <= q_desc.src;
      res.target_addr   <= q_desc.tgt;
      res.command       <= q_desc.cmd;
      res.sequence_res  <= q_desc.seq;
      res.payload_len   <= q_desc.len[5:0];
      res.has_payload   <= has_pl;
      res.byte_position <= has_pl ? 5'(k_pend) : 5'd0;
      res.payload_byte  <= has_pl ? ram_rdata : 8'd0;
      res.last          <= last_pend;
    end
    if (rst) begin
      k         <= '0;
      rd_pend   <= 1'b0;
      res.valid <= 1'b0;
    end else begin
      rd_pend <= issue;
      if (issue) k <= is_last ? '0 : k + IDX_W'(1);
      if (rd_pend) begin
        res.valid <= 1'b1;
      end else if (res.ready) begin
        res.valid <= 1'b0;
      end
    end
  end

  a_single_read: assert property (@(posedge clk) disable iff (rst) rd_pend |=> !rd_pend)
    else $error("back-to-back RAM reads");

  a_read_has_desc: assert property (@(posedge clk) disable iff (rst) rd_pend |-> q_valid)
    else $error("read data without descriptor");

endmodule

@@ sv/sof_frame_parser_crc8.sv @@
// Start-of-frame byte parser with CRC-8/ATM check. Received bytes are taken at one per
// cycle while fewer than two checked frames wait; the descriptor queue depth sets that bound.
// After the CRC byte is taken, its descriptor is registered in the queue, then the RAM read
// and the output register follow; the back end starts no new read while one is pending.
// Reset is synchronous and active high: hunt state, start bytes 0xAA and 0x55, queue
// empty; the payload RAM is not cleared.
module sof_frame_parser_crc8 #(
  parameter int MAX_PAYLOAD = sfp_pkg::MAX_PAYLOAD_DFLT
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       cfg_we,
  input  logic       cfg_index,
  input  logic [7:0] cfg_data,
  sfp_rx_if.sink     rx,
  sfp_res_if.source  res
);

  localparam int IDX_W = (MAX_PAYLOAD > 1) ? $clog2(MAX_PAYLOAD) : 1;

  logic           ram_we;
  logic [IDX_W:0] ram_waddr;
  logic [7:0]     ram_wdata;
  logic [IDX_W:0] ram_raddr;
  logic [7:0]     ram_rdata;
  logic           q_full;
  logic           q_push;
  logic           q_pop;
  logic           q_valid;
  sfp_pkg::desc_t push_desc;
  sfp_pkg::desc_t head_desc;

  sfp_front #(.MAX_PAYLOAD(MAX_PAYLOAD), .IDX_W(IDX_W)) u_front (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .rx        (rx),
    .ram_we    (ram_we),
    .ram_waddr (ram_waddr),
    .ram_wdata (ram_wdata),
    .q_full    (q_full),
    .q_push    (q_push),
    .q_desc    (push_desc)
  );

  sfp_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (q_push),
    .push_desc  (push_desc),
    .full       (q_full),
    .pop        (q_pop),
    .head_valid (q_valid),
    .head_desc  (head_desc)
  );

  sfp_ram #(.WIDTH(8), .DEPTH(2 << IDX_W)) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  sfp_back #(.MAX_PAYLOAD(MAX_PAYLOAD), .IDX_W(IDX_W)) u_back (
    .clk       (clk),
    .rst       (rst),
    .q_valid   (q_valid),
    .q_desc    (head_desc),
    .q_pop     (q_pop),
    .ram_raddr (ram_raddr),
    .ram_rdata (ram_rdata),
    .res       (res)
  );

endmodule
